// ===== hdl/srga_pkg.sv =====
// Shared types and constants for the sorted-run group aggregator.
// No dependencies; imported by every module of the block.
package srga_pkg;

    // Fixed field widths of the row and result channels
    localparam int FIELD_W     = 64;
    localparam int KEY_W       = 64;
    localparam int MAX_COLUMNS = 4;
    localparam int CFG_DATA_W  = 8;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Grouping modes (a code of 3 behaves as aggregate)
    localparam logic [1:0] GRP_DUPLICATE = 2'd0;
    localparam logic [1:0] GRP_UNIQUE    = 2'd1;
    localparam logic [1:0] GRP_AGGREGATE = 2'd2;

    // Configuration register indexes
    localparam logic REG_GROUP_MODE = 1'b0;
    localparam logic REG_COLUMN_OPS = 1'b1;

    // Per-column merge operation
    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_MAX   = 2'd1,
        OP_MIN   = 2'd2,
        OP_SUM   = 2'd3
    } col_op_t;

    // One emitted group
    typedef struct packed {
        logic [KEY_W-1:0]                      key;
        logic [MAX_COLUMNS-1:0][FIELD_W-1:0]   values;
        logic [MAX_COLUMNS-1:0]                nulls;
        logic                                  run_end;
    } result_t;

endpackage

// ===== hdl/srga_column.sv =====
// Merge logic for one value column: folds an incoming nullable value into
// the held aggregate. Depends on srga_pkg.
module srga_column (
    input  logic                          keep,
    input  srga_pkg::col_op_t             op,
    input  logic [srga_pkg::FIELD_W-1:0]  held_value,
    input  logic                          held_null,
    input  logic [srga_pkg::FIELD_W-1:0]  row_value,
    input  logic                          row_null,
    output logic [srga_pkg::FIELD_W-1:0]  merged_value,
    output logic                          merged_null
);
    import srga_pkg::*;

    // Apply the column operation unless the group keeps its first row
    always_comb
    begin
        merged_value = held_value;
        merged_null  = held_null;
        if (!keep)
        begin
            unique case (op)
                OP_FIRST:
                begin
                    merged_value = held_value;
                end
                OP_MAX:
                begin
                    if (!held_null && !row_null)
                    begin
                        if ($signed(held_value) < $signed(row_value))
                            merged_value = row_value;
                    end
                    else if (held_null && !row_null)
                    begin
                        merged_value = row_value;
                        merged_null  = 1'b0;
                    end
                end
                OP_MIN:
                begin
                    if (!held_null && !row_null)
                    begin
                        if ($signed(row_value) < $signed(held_value))
                            merged_value = row_value;
                    end
                    else if (!held_null && row_null)
                    begin
                        merged_null = 1'b1;
                    end
                end
                OP_SUM:
                begin
                    if (!held_null && !row_null)
                    begin
                        merged_value = held_value + row_value;
                    end
                    else if (held_null && !row_null)
                    begin
                        merged_value = row_value;
                        merged_null  = 1'b0;
                    end
                end
                default:
                begin
                    merged_value = held_value;
                end
            endcase
        end
    end

endmodule

// ===== hdl/srga_result_queue.sv =====
// Small result queue that takes up to two groups per cycle and hands out
// one per output request. Depends on srga_pkg.
module srga_result_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_cnt,
    input  srga_pkg::result_t [1:0]       push_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output srga_pkg::result_t             head,
    output logic [srga_pkg::QCNT_W-1:0]   count
);
    import srga_pkg::*;

    result_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write one or two entries
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push_data[0];
        if (push_cnt == 2'd2)
            mem[wr_ptr_reg + QPTR_W'(1)] <= push_data[1];
    end

endmodule

// ===== hdl/sorted_run_group_aggregator.sv =====
// Sorted-run group aggregator: takes key-sorted rows and emits one result per
// closed group. Depends on srga_pkg, srga_column and srga_result_queue.

// A row is taken into an input register, and in the next cycle one pass of
// key compare and per-column first/max/min/sum logic updates the open group and
// writes zero, one or two results into a four-entry result queue. One row is
// accepted per cycle; in_ready drops only while the queue could not absorb
// two more results, so a consumer that takes a result every cycle never
// stalls the row stream while each row causes at most one result;
// back-to-back rows that each close two groups fill the queue and drop
// in_ready until it drains. The results of a row pass through the input
// register and then the result queue before they appear on the output.
// Configuration writes are taken at any time but must only be issued while
// no row is in flight.
module sorted_run_group_aggregator #(
    parameter int NUM_COLUMNS = 4,
    parameter int KEY_BITS    = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [srga_pkg::CFG_DATA_W-1:0] cfg_data,
    // row channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [63:0]                     row_key,
    input  logic signed [63:0]              value_a,
    input  logic signed [63:0]              value_b,
    input  logic signed [63:0]              value_c,
    input  logic signed [63:0]              value_d,
    input  logic                            null_a,
    input  logic                            null_b,
    input  logic                            null_c,
    input  logic                            null_d,
    input  logic                            final_row,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [63:0]                     group_key_out,
    output logic signed [63:0]              agg_a,
    output logic signed [63:0]              agg_b,
    output logic signed [63:0]              agg_c,
    output logic signed [63:0]              agg_d,
    output logic                            agg_null_a,
    output logic                            agg_null_b,
    output logic                            agg_null_c,
    output logic                            agg_null_d,
    output logic                            run_end
);
    import srga_pkg::*;

    // Configuration registers
    logic [1:0]             group_mode_reg;
    logic [CFG_DATA_W-1:0]  column_ops_reg;

    // Input register
    logic                               row_valid_reg;
    logic [KEY_BITS-1:0]                row_key_reg;
    logic [NUM_COLUMNS-1:0][FIELD_W-1:0] row_values_reg;
    logic [NUM_COLUMNS-1:0]             row_nulls_reg;
    logic                               row_final_reg;

    // Open group
    logic                               group_open_reg;
    logic                               group_open_next;
    logic [KEY_BITS-1:0]                held_key_reg;
    logic [KEY_BITS-1:0]                held_key_next;
    logic [NUM_COLUMNS-1:0][FIELD_W-1:0] held_values_reg;
    logic [NUM_COLUMNS-1:0][FIELD_W-1:0] held_values_next;
    logic [NUM_COLUMNS-1:0]             held_nulls_reg;
    logic [NUM_COLUMNS-1:0]             held_nulls_next;

    logic [NUM_COLUMNS-1:0][FIELD_W-1:0] merged_values;
    logic [NUM_COLUMNS-1:0]             merged_nulls;
    logic [MAX_COLUMNS-1:0][FIELD_W-1:0] in_values;
    logic [MAX_COLUMNS-1:0]             in_nulls;
    logic [MAX_COLUMNS-1:0][FIELD_W-1:0] old_values_out;
    logic [MAX_COLUMNS-1:0]             old_nulls_out;
    logic [MAX_COLUMNS-1:0][FIELD_W-1:0] new_values_out;
    logic [MAX_COLUMNS-1:0]             new_nulls_out;

    logic                   merging;
    logic                   keep_first;
    logic                   key_match;
    logic                   start_group;
    logic                   emit_old;
    logic [1:0]             push_cnt;
    result_t [1:0]          push_data;
    result_t                old_group;
    result_t                new_group;
    result_t                head;
    logic [QCNT_W-1:0]      q_count;
    logic [QCNT_W-1:0]      q_count_after;
    logic                   in_accept;

    assign in_values = {value_d, value_c, value_b, value_a};
    assign in_nulls  = {null_d, null_c, null_b, null_a};

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_mode_reg <= GRP_AGGREGATE;
            column_ops_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GROUP_MODE: group_mode_reg <= cfg_data[1:0];
                REG_COLUMN_OPS: column_ops_reg <= cfg_data;
                default:        group_mode_reg <= group_mode_reg;
            endcase
        end
    end

    // Hold room for two results beyond what the queue already owes
    assign q_count_after = q_count + QCNT_W'(push_cnt) - QCNT_W'(out_valid && out_ready);
    assign in_ready      = (q_count_after <= QCNT_W'(QDEPTH - 2));
    assign in_accept     = in_valid && in_ready;

    // Capture the accepted row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= 1'b0;
        else
            row_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            row_key_reg    <= row_key[KEY_BITS-1:0];
            row_values_reg <= in_values[NUM_COLUMNS-1:0];
            row_nulls_reg  <= in_nulls[NUM_COLUMNS-1:0];
            row_final_reg  <= final_row;
        end
    end

    // Decide merge, emit and flush
    assign merging     = (group_mode_reg != GRP_DUPLICATE);
    assign keep_first  = (group_mode_reg == GRP_UNIQUE);
    assign key_match   = (row_key_reg == held_key_reg);
    assign start_group = !group_open_reg || !(merging && key_match);
    assign emit_old    = row_valid_reg && group_open_reg && !(merging && key_match);

    // Per-column merge units
    for (genvar c = 0; c < NUM_COLUMNS; c++)
    begin : g_col
        srga_column u_column (
            .keep         (keep_first),
            .op           (col_op_t'(column_ops_reg[2*c +: 2])),
            .held_value   (held_values_reg[c]),
            .held_null    (held_nulls_reg[c]),
            .row_value    (row_values_reg[c]),
            .row_null     (row_nulls_reg[c]),
            .merged_value (merged_values[c]),
            .merged_null  (merged_nulls[c])
        );
    end

    // Next group contents
    always_comb
    begin
        group_open_next  = group_open_reg;
        held_key_next    = held_key_reg;
        held_values_next = held_values_reg;
        held_nulls_next  = held_nulls_reg;
        if (row_valid_reg)
        begin
            if (start_group)
            begin
                held_key_next    = row_key_reg;
                held_values_next = row_values_reg;
                held_nulls_next  = row_nulls_reg;
            end
            else
            begin
                held_values_next = merged_values;
                held_nulls_next  = merged_nulls;
            end
            group_open_next = !row_final_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            group_open_reg <= 1'b0;
        else
            group_open_reg <= group_open_next;
    end

    always_ff @(posedge clk)
    begin
        held_key_reg    <= held_key_next;
        held_values_reg <= held_values_next;
        held_nulls_reg  <= held_nulls_next;
    end

    // Widen groups to the full result layout; absent columns read as zero
    for (genvar c = 0; c < MAX_COLUMNS; c++)
    begin : g_res
        if (c < NUM_COLUMNS)
        begin : g_live
            assign old_values_out[c] = held_values_reg[c];
            assign old_nulls_out[c]  = held_nulls_reg[c];
            assign new_values_out[c] = held_values_next[c];
            assign new_nulls_out[c]  = held_nulls_next[c];
        end
        else
        begin : g_absent
            assign old_values_out[c] = '0;
            assign old_nulls_out[c]  = 1'b0;
            assign new_values_out[c] = '0;
            assign new_nulls_out[c]  = 1'b0;
        end
    end

    // Build the results of this row in order
    always_comb
    begin
        old_group.key     = KEY_W'(held_key_reg);
        old_group.values  = old_values_out;
        old_group.nulls   = old_nulls_out;
        old_group.run_end = !row_final_reg;
        new_group.key     = KEY_W'(held_key_next);
        new_group.values  = new_values_out;
        new_group.nulls   = new_nulls_out;
        new_group.run_end = 1'b1;
        push_cnt          = 2'(emit_old) + 2'(row_valid_reg && row_final_reg);
        if (emit_old)
        begin
            push_data[0] = old_group;
            push_data[1] = new_group;
        end
        else
        begin
            push_data[0] = new_group;
            push_data[1] = new_group;
        end
    end

    srga_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .count     (q_count)
    );

    assign group_key_out = head.key;
    assign agg_a         = head.values[0];
    assign agg_b         = head.values[1];
    assign agg_c         = head.values[2];
    assign agg_d         = head.values[3];
    assign agg_null_a    = head.nulls[0];
    assign agg_null_b    = head.nulls[1];
    assign agg_null_c    = head.nulls[2];
    assign agg_null_d    = head.nulls[3];
    assign run_end       = head.run_end;

    // Queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n) q_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // A final row always leaves the block without an open group
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg && row_final_reg |=> !group_open_reg)
        else $error("group still open after final row");

    // A row in flight always finds room for both of its possible results
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg |-> (q_count - QCNT_W'(out_valid && out_ready)) <= QCNT_W'(QDEPTH - 2))
        else $error("row processed without queue room");

endmodule

// ===== tb/sv/group_result_monitor.sv =====
// Monitor for the sorted-run group aggregator: follows the config port and
// both request channels, predicts every emitted group and compares it.
// Depends on srga_pkg for the result layout, op codes and register indexes.
module group_result_monitor #(
    parameter int NUM_COLUMNS = 4,
    parameter int KEY_BITS    = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [srga_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [63:0]                     row_key,
    input  logic signed [63:0]              value_a,
    input  logic signed [63:0]              value_b,
    input  logic signed [63:0]              value_c,
    input  logic signed [63:0]              value_d,
    input  logic                            null_a,
    input  logic                            null_b,
    input  logic                            null_c,
    input  logic                            null_d,
    input  logic                            final_row,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [63:0]                     group_key_out,
    input  logic signed [63:0]              agg_a,
    input  logic signed [63:0]              agg_b,
    input  logic signed [63:0]              agg_c,
    input  logic signed [63:0]              agg_d,
    input  logic                            agg_null_a,
    input  logic                            agg_null_b,
    input  logic                            agg_null_c,
    input  logic                            agg_null_d,
    input  logic                            run_end,
    input  logic                            drain_done,
    output int                              fail_count,
    output int                              outstanding,
    output int                              rows_taken,
    output int                              groups_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import srga_pkg::*;

    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

    // Shadow configuration
    logic [1:0]             grouping;
    logic [7:0]             col_ops;

    // Shadow of the open group
    logic                   group_held;
    logic [63:0]            held_key;
    logic [MAX_COLUMNS-1:0][63:0] held_vals;
    logic [MAX_COLUMNS-1:0] held_nulls;

    // Groups predicted but not yet seen on the output
    result_t                awaited_groups[$];
    bit                     leftover_checked;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Load the held group from one row; dead columns read as zero
    task automatic open_group(input logic [63:0] key, input logic [3:0][63:0] vals,
                              input logic [3:0] nulls);
        held_key = key;
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            held_vals[c]  = (c < NUM_COLUMNS) ? vals[c] : '0;
            held_nulls[c] = (c < NUM_COLUMNS) ? nulls[c] : 1'b0;
        end
        group_held = 1'b1;
    endtask

    // Fold one incoming value into a held column
    task automatic merge_column(input int c, input col_op_t op, input logic [63:0] v,
                                input logic vnull);
        logic signed [63:0] h;
        logic signed [63:0] sv;
        h  = held_vals[c];
        sv = v;
        case (op)
            OP_MAX:
            begin
                if (!held_nulls[c] && !vnull)
                begin
                    if (sv > h)
                        held_vals[c] = v;
                end
                else if (held_nulls[c] && !vnull)
                begin
                    held_vals[c]  = v;
                    held_nulls[c] = 1'b0;
                end
            end
            OP_MIN:
            begin
                if (!held_nulls[c] && !vnull)
                begin
                    if (sv < h)
                        held_vals[c] = v;
                end
                else if (!held_nulls[c] && vnull)
                    held_nulls[c] = 1'b1;
            end
            OP_SUM:
            begin
                if (!held_nulls[c] && !vnull)
                    held_vals[c] = h + sv;
                else if (held_nulls[c] && !vnull)
                begin
                    held_vals[c]  = v;
                    held_nulls[c] = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic result_t held_group();
        result_t r;
        r.key = held_key & KEY_MASK;
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            r.values[c] = (c < NUM_COLUMNS) ? held_vals[c] : '0;
            r.nulls[c]  = (c < NUM_COLUMNS) && held_nulls[c];
        end
        r.run_end = 1'b0;
        return r;
    endfunction

    // Predict the groups that one accepted row closes
    task automatic absorb_row();
        logic [3:0][63:0] vals;
        logic [3:0]       nulls;
        logic [63:0]      key;
        int               base;
        vals  = {value_d, value_c, value_b, value_a};
        nulls = {null_d, null_c, null_b, null_a};
        key   = row_key & KEY_MASK;
        base  = awaited_groups.size();
        rows_taken++;
        if (!group_held)
            open_group(key, vals, nulls);
        else if (grouping != GRP_DUPLICATE && key == held_key)
        begin
            // unique mode keeps the first row untouched
            if (grouping != GRP_UNIQUE)
                for (int c = 0; c < NUM_COLUMNS && c < MAX_COLUMNS; c++)
                    merge_column(c, col_op_t'(col_ops[2*c +: 2]), vals[c], nulls[c]);
        end
        else
        begin
            awaited_groups = {awaited_groups, held_group()};
            open_group(key, vals, nulls);
        end
        if (final_row)
        begin
            awaited_groups = {awaited_groups, held_group()};
            group_held = 1'b0;
        end
        // flag the last group this row produced
        if (awaited_groups.size() > base)
            awaited_groups[awaited_groups.size()-1].run_end = 1'b1;
    endtask

    // Compare one delivered group against the oldest prediction
    task automatic check_group();
        result_t got;
        result_t want;
        got.key     = group_key_out;
        got.values  = {agg_d, agg_c, agg_b, agg_a};
        got.nulls   = {agg_null_d, agg_null_c, agg_null_b, agg_null_a};
        got.run_end = run_end;
        groups_checked++;
        if (awaited_groups.size() == 0)
        begin
            report_mismatch("group with none awaited (key)", got.key, '0);
            return;
        end
        want = awaited_groups.pop_front();
        if (got.key !== want.key)
            report_mismatch("group key", got.key, want.key);
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            if (got.values[c] !== want.values[c])
                report_mismatch($sformatf("aggregate of column %0d", c),
                                got.values[c], want.values[c]);
            if (got.nulls[c] !== want.nulls[c])
                report_mismatch($sformatf("null flag of column %0d", c),
                                64'(got.nulls[c]), 64'(want.nulls[c]));
        end
        if (got.run_end !== want.run_end)
            report_mismatch("run_end", 64'(got.run_end), 64'(want.run_end));
    endtask

    // Sample all channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grouping         = GRP_AGGREGATE;
            col_ops          = '0;
            group_held       = 1'b0;
            held_key         = '0;
            held_vals        = '0;
            held_nulls       = '0;
            leftover_checked = 1'b0;
            awaited_groups.delete();
            fail_count       = 0;
            rows_taken       = 0;
            groups_checked   = 0;
            outstanding     <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_group();
            if (in_valid && in_ready)
                absorb_row();
            if (cfg_we)
            begin
                if (cfg_index == REG_GROUP_MODE)
                    grouping = cfg_data[1:0];
                else
                    col_ops = cfg_data[7:0];
            end
            // anything still awaited at the end was lost
            if (drain_done && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (awaited_groups.size() != 0)
                    report_mismatch("groups never delivered",
                                    64'(awaited_groups.size()), '0);
            end
            outstanding <= awaited_groups.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the group aggregator testbench: clock, reset, row and result traffic.
// Depends on srga_pkg, sorted_run_group_aggregator and group_result_monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srga_pkg::*;

    localparam int STALL_LIMIT    = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int NUM_PHASES     = 12;
    localparam int ROWS_PER_PHASE = 153;
    localparam int PAUSE_PHASE    = 2;
    localparam int PRESSURE_PHASE = 9;

    // Grouping code 3 is undefined by name and must act as aggregate
    localparam logic [1:0] GRP_AGGREGATE_ALT = 2'd3;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One row request; bit c of nulls and vals[c] belong to column c (a = 0)
    typedef struct packed {
        logic [63:0]      key;
        logic [3:0][63:0] vals;
        logic [3:0]       nulls;
        logic             last;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [63:0]           row_key;
    logic signed [63:0]    value_a;
    logic signed [63:0]    value_b;
    logic signed [63:0]    value_c;
    logic signed [63:0]    value_d;
    logic                  null_a;
    logic                  null_b;
    logic                  null_c;
    logic                  null_d;
    logic                  final_row;
    logic                  out_valid;
    logic                  out_ready;
    logic [63:0]           group_key_out;
    logic signed [63:0]    agg_a;
    logic signed [63:0]    agg_b;
    logic signed [63:0]    agg_c;
    logic signed [63:0]    agg_d;
    logic                  agg_null_a;
    logic                  agg_null_b;
    logic                  agg_null_c;
    logic                  agg_null_d;
    logic                  run_end;

    logic                  drain_done;
    int                    fail_count;
    int                    outstanding;
    int                    rows_taken;
    int                    groups_checked;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    pressure_epoch;
    int                    quiet_cycles;

    // Per-phase register settings
    logic [1:0] mode_plan [NUM_PHASES] = '{GRP_AGGREGATE, GRP_AGGREGATE,
                                           GRP_AGGREGATE, GRP_AGGREGATE,
                                           GRP_UNIQUE, GRP_DUPLICATE,
                                           GRP_AGGREGATE_ALT, GRP_AGGREGATE,
                                           GRP_UNIQUE, GRP_DUPLICATE,
                                           GRP_AGGREGATE_ALT, GRP_AGGREGATE};
    logic [7:0] ops_plan [NUM_PHASES]  = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                                           8'h00, 8'h00, 8'h1B, 8'h00,
                                           8'hFF, 8'h00, 8'h00, 8'hE4};
    bit         ops_random [NUM_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0,
                                            1'b1, 1'b1, 1'b0, 1'b1,
                                            1'b0, 1'b0, 1'b1, 1'b0};

    sorted_run_group_aggregator i_dut (.*);

    group_result_monitor i_monitor (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run when no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold per pressure request
    initial
    begin
        int served;
        served = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_epoch != served)
            begin
                served = pressure_epoch;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Mostly random values, with a bias toward the signed extremes
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return ALL_ONES;
            4: return {56'd0, 8'($urandom_range(0, 200))} - 64'd100;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic row_t random_row(input logic [63:0] key);
        row_t r;
        r.key = key;
        for (int c = 0; c < 4; c++)
        begin
            r.vals[c]  = pick_value();
            r.nulls[c] = ($urandom_range(0, 3) == 0);
        end
        r.last = 1'b0;
        return r;
    endfunction

    // Offer one row after a random gap and hold it until accepted
    task automatic push_row(input row_t r);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_key   <= r.key;
        value_a   <= r.vals[0];
        value_b   <= r.vals[1];
        value_c   <= r.vals[2];
        value_d   <= r.vals[3];
        null_a    <= r.nulls[0];
        null_b    <= r.nulls[1];
        null_c    <= r.nulls[2];
        null_d    <= r.nulls[3];
        final_row <= r.last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_row(input logic [63:0] key, input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] c, input logic [63:0] d,
                            input logic [3:0] nulls, input logic last);
        row_t r;
        r.key   = key;
        r.vals  = {d, c, b, a};
        r.nulls = nulls;
        r.last  = last;
        push_row(r);
    endtask

    // Wait for every awaited group, then let the pipeline settle
    task automatic drain_results();
        int guard;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on consecutive edges; spare mode bits get noise
    task automatic write_config(input logic [1:0] mode, input logic [7:0] ops);
        logic [5:0] pad;
        pad = 6'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GROUP_MODE;
        cfg_data  <= {pad, mode};
        @(posedge clk);
        cfg_index <= REG_COLUMN_OPS;
        cfg_data  <= ops;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sorted runs of equal keys with random content, some noise keys and
    // stray final flags; the last row always closes the open group
    task automatic run_phase(input int n_rows, input bit mid_pause);
        int          sent;
        int          run_len;
        logic [63:0] run_key;
        row_t        r;
        sent    = 0;
        run_key = {$urandom, $urandom};
        while (sent < n_rows)
        begin
            case ($urandom_range(0, 9))
                0: run_key = {$urandom, $urandom};
                1: run_key = run_key ^ (64'd1 << $urandom_range(0, 63));
                default: run_key = run_key + 64'($urandom_range(1, 50));
            endcase
            run_len = $urandom_range(1, 6);
            for (int k = 0; k < run_len && sent < n_rows; k++)
            begin
                r      = random_row(run_key);
                r.last = (sent == n_rows - 1) || ($urandom_range(0, 99) < 2);
                if (mid_pause && sent == n_rows / 2)
                begin
                    in_valid <= 1'b0;
                    drain_results();
                end
                push_row(r);
                sent++;
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_GROUP_MODE;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        row_key        <= '0;
        value_a        <= '0;
        value_b        <= '0;
        value_c        <= '0;
        value_d        <= '0;
        null_a         <= 1'b0;
        null_b         <= 1'b0;
        null_c         <= 1'b0;
        null_d         <= 1'b0;
        final_row      <= 1'b0;
        drain_done     <= 1'b0;
        pressure_epoch <= 0;
        recv_idle_pct  <= 53;
        send_idle_pct   = 36;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: a keep-first, b max, c min, d sum
        write_config(GRP_AGGREGATE, 8'hE4);
        // final row with nothing held: open and emit at once
        send_row(64'd0, MOST_POS, MOST_NEG, 64'd0, ALL_ONES, 4'b0000, 1'b1);
        // open on the all-ones key with b null; no result yet
        send_row(ALL_ONES, MOST_NEG, 64'd5, MOST_POS, MOST_POS, 4'b0010, 1'b0);
        // max adopts into a null group, min drops to the floor, sum wraps
        send_row(ALL_ONES, 64'd1, MOST_NEG, MOST_NEG, 64'd1, 4'b0000, 1'b0);
        // null into min turns the group null; sum wraps back
        send_row(ALL_ONES, 64'd2, MOST_POS, 64'd3, ALL_ONES, 4'b0100, 1'b0);
        // null into max and sum leaves them; min stays null
        send_row(ALL_ONES, 64'd9, 64'd7, MOST_NEG, 64'd4, 4'b1010, 1'b0);
        // new key: emit, open an all-null group that keeps its raw values
        send_row(64'd1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 4'b1111, 1'b0);
        // present values into null group: max and sum adopt, min and first stay null
        send_row(64'd1, 64'd10, ALL_ONES, 64'd10, MOST_NEG, 4'b0000, 1'b1);
        // keys one apart in the low bit, second final: two results
        send_row(64'd2, 64'd1, 64'd2, 64'd3, 64'd4, 4'b0000, 1'b0);
        send_row(64'd3, 64'd5, 64'd6, 64'd7, 64'd8, 4'b0101, 1'b1);
        // keys apart only in the top bit
        send_row(MOST_NEG, ALL_ONES, 64'd0, ALL_ONES, 64'd0, 4'b0000, 1'b0);
        send_row(64'd0, 64'd0, ALL_ONES, 64'd0, ALL_ONES, 4'b1000, 1'b1);
        // signed ordering: -1 against 1 in max and min
        send_row(64'd7, 64'd1, ALL_ONES, 64'd1, 64'd1, 4'b0000, 1'b0);
        send_row(64'd7, 64'd2, 64'd1, ALL_ONES, ALL_ONES, 4'b0000, 1'b1);
        in_valid <= 1'b0;
        drain_results();

        // Random phases over the register plan and three idle mixes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 4)
            begin
                send_idle_pct  = 53;
                recv_idle_pct <= 36;
            end
            if (p == 8)
            begin
                send_idle_pct  = 0;
                recv_idle_pct <= 0;
            end
            write_config(mode_plan[p], ops_random[p] ? 8'($urandom) : ops_plan[p]);
            if (p == PRESSURE_PHASE)
                pressure_epoch <= pressure_epoch + 1;
            run_phase(ROWS_PER_PHASE, p == PAUSE_PHASE);
            drain_results();
        end

        drain_done <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Run took %0d rows and checked %0d groups over all four grouping codes",
                 rows_taken, groups_checked);
        $display("and %0d column-op settings, with mixed idling and a %0d-cycle output hold.",
                 NUM_PHASES + 1, LONG_HOLD);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
